### hw/rtl/srb_pkg.sv
// Shared types and constants for the serial line byte reassembler.
// No dependencies; every other file in this block but srb_checker refers to it by scoped names.
`timescale 1ns / 1ps

package srb_pkg;

   // field widths
   localparam int BYTE_W     = 8;
   localparam int CYCLES_W   = 4;
   localparam int BITCNT_W   = 4;
   localparam int CNT_W      = 10;
   localparam int CMP_W      = 13;
   localparam int CSR_IDX_W  = 2;
   // data samples plus the stop sample
   localparam int SAMPLE_SPAN = BYTE_W + 1;

   // register indexes on the csr channel
   localparam logic [CSR_IDX_W-1:0] CSR_BIT_PERIOD  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CAPS_CODE   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LAYOUT_CODE = 2'd2;

   // register reset values
   localparam logic [BYTE_W-1:0] BIT_PERIOD_RST  = 8'd64;
   localparam logic [BYTE_W-1:0] CAPS_CODE_RST   = 8'o260;
   localparam logic [BYTE_W-1:0] LAYOUT_CODE_RST = 8'o262;

   // frame phase
   typedef enum logic [2:0] {
      PH_IDLE = 3'b001,
      PH_DATA = 3'b010,
      PH_STOP = 3'b100
   } phase_type;

   typedef struct packed {
      logic [BYTE_W-1:0] bit_period;
      logic [BYTE_W-1:0] caps_code;
      logic [BYTE_W-1:0] layout_code;
   } cfg_type;

   typedef struct packed {
      phase_type                phase;
      logic signed [CNT_W-1:0]  counter;
      logic [BITCNT_W-1:0]      bit_count;
      logic [BYTE_W-1:0]        shift_byte;
      logic                     prev_level;
      logic                     caps_state;
      logic                     layout_state;
   } frame_state_type;

endpackage

### hw/rtl/srb_if.sv
// Valid/ready channel interfaces for the serial line byte reassembler:
// line sample requests, received byte responses and register writes. Uses srb_pkg.
`timescale 1ns / 1ps

interface srb_req_if;
   logic                          valid;
   logic                          ready;
   logic                          line_level;
   logic [srb_pkg::CYCLES_W-1:0]  cycles_elapsed;

   modport source (output valid, line_level, cycles_elapsed, input ready);
   modport sink   (input valid, line_level, cycles_elapsed, output ready);
endinterface

interface srb_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [srb_pkg::BYTE_W-1:0]  received_byte;
   logic                        caps_flag;
   logic                        layout_flag;

   modport source (output valid, received_byte, caps_flag, layout_flag, input ready);
   modport sink   (input valid, received_byte, caps_flag, layout_flag, output ready);
endinterface

interface srb_csr_if;
   logic                           valid;
   logic                           ready;
   logic [srb_pkg::CSR_IDX_W-1:0]  reg_index;
   logic [srb_pkg::BYTE_W-1:0]     write_data;

   modport source (output valid, reg_index, write_data, input ready);
   modport sink   (input valid, reg_index, write_data, output ready);
endinterface

### hw/rtl/serial_line_byte_reassembler.sv
// Top level of the serial line byte reassembler: request and response registers,
// configuration registers and frame state. Uses srb_pkg, srb_if and srb_frame_step.
`timescale 1ns / 1ps
//
// Usage
//   req_chan  : one line sample per request: the line level and the machine
//               cycles elapsed since the previous sample.
//   rsp_chan  : one response per byte whose stop sample was high, carrying the
//               byte and both toggle flags after it; other requests give none.
//   csr_chan  : register writes (bit period, caps code, layout code), always
//               ready; write only while no request is in flight.
// Path: a taken request waits in the request register, is evaluated from there,
//   and its response is loaded into the response register as the request advances.
// Throughput: one request per cycle unless a held response stalls it; all samples
//   that fall within one request are resolved in a single pass of the next-state
//   logic between the request register and the state and response registers.
// Reset: synchronous; clears the frame state, the toggle flags and both valid
//   registers, and loads the register reset values.
// Stall: a held response blocks the request register only when that register
//   is full; one request waits there while the response waits to be taken.

module serial_line_byte_reassembler (
   input  logic           clock,
   input  logic           reset,
   srb_req_if.sink        req_chan,
   srb_rsp_if.source      rsp_chan,
   srb_csr_if.sink        csr_chan
);

   srb_pkg::cfg_type                  cfg_ff, cfg_in;
   srb_pkg::frame_state_type          state_ff, state_in, state_next;
   logic                              in_valid_ff, in_valid_in;
   logic                              in_level_ff;
   logic [srb_pkg::CYCLES_W-1:0]      in_cycles_ff;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [srb_pkg::BYTE_W-1:0]        rsp_byte_ff;
   logic                              rsp_caps_ff;
   logic                              rsp_layout_ff;
   logic                              emit;
   logic                              advance;
   logic                              req_take;

   // handshakes
   assign advance          = in_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready   = !in_valid_ff || advance;
   assign req_take         = req_chan.valid && req_chan.ready;
   assign csr_chan.ready   = 1'b1;

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.received_byte = rsp_byte_ff;
   assign rsp_chan.caps_flag     = rsp_caps_ff;
   assign rsp_chan.layout_flag   = rsp_layout_ff;

   // register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_chan.valid) begin
         case (csr_chan.reg_index)
            srb_pkg::CSR_BIT_PERIOD:  cfg_in.bit_period  = csr_chan.write_data;
            srb_pkg::CSR_CAPS_CODE:   cfg_in.caps_code   = csr_chan.write_data;
            srb_pkg::CSR_LAYOUT_CODE: cfg_in.layout_code = csr_chan.write_data;
            default:                  cfg_in = cfg_ff;
         endcase
      end
   end

   // sample evaluation
   srb_frame_step u_step (
      .state_in       (state_ff),
      .cfg            (cfg_ff),
      .line_level     (in_level_ff),
      .cycles_elapsed (in_cycles_ff),
      .state_out      (state_next),
      .emit           (emit)
   );

   // next values of the control registers
   always_comb begin
      in_valid_in  = req_take || (in_valid_ff && !advance);
      state_in     = advance ? state_next : state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      if (advance && emit) begin
         rsp_valid_in = 1'b1;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.bit_period     <= srb_pkg::BIT_PERIOD_RST;
         cfg_ff.caps_code      <= srb_pkg::CAPS_CODE_RST;
         cfg_ff.layout_code    <= srb_pkg::LAYOUT_CODE_RST;
         state_ff.phase        <= srb_pkg::PH_IDLE;
         state_ff.counter      <= '0;
         state_ff.bit_count    <= '0;
         state_ff.shift_byte   <= '0;
         state_ff.prev_level   <= 1'b0;
         state_ff.caps_state   <= 1'b0;
         state_ff.layout_state <= 1'b0;
         in_valid_ff           <= 1'b0;
         rsp_valid_ff          <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         state_ff     <= state_in;
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // request and response payload
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_level_ff  <= req_chan.line_level;
         in_cycles_ff <= req_chan.cycles_elapsed;
      end
      if (advance && emit) begin
         rsp_byte_ff   <= state_next.shift_byte;
         rsp_caps_ff   <= state_next.caps_state;
         rsp_layout_ff <= state_next.layout_state;
      end
   end

endmodule

### hw/rtl/srb_frame_step.sv
// Next-state logic for one line sample: start detection, all samples due
// within the elapsed cycles, stop check and toggle flags. Uses srb_pkg.
`timescale 1ns / 1ps

module srb_frame_step (
   input  srb_pkg::frame_state_type           state_in,
   input  srb_pkg::cfg_type                   cfg,
   input  logic                               line_level,
   input  logic [srb_pkg::CYCLES_W-1:0]       cycles_elapsed,
   output srb_pkg::frame_state_type           state_out,
   output logic                               emit
);

   logic signed [srb_pkg::CMP_W-1:0]     left_w;
   logic [srb_pkg::CMP_W-1:0]            period_w;
   logic [srb_pkg::SAMPLE_SPAN-1:0]      due;
   logic [srb_pkg::BITCNT_W-1:0]         due_count;
   logic [srb_pkg::BITCNT_W-1:0]         room;
   logic [srb_pkg::BITCNT_W-1:0]         take;
   logic                                 stop_hit;
   logic [srb_pkg::BITCNT_W:0]           take_end;
   logic [srb_pkg::BYTE_W-1:0]           fill_mask;
   logic [srb_pkg::BYTE_W-1:0]           new_byte;
   logic [srb_pkg::BITCNT_W-1:0]         new_count;

   // counter after this request's cycles, widened for the compares
   assign left_w = srb_pkg::CMP_W'(state_in.counter)
                   - signed'(srb_pkg::CMP_W'(cycles_elapsed));
   assign period_w = srb_pkg::CMP_W'(cfg.bit_period);

   // sample n is due when the counter plus n periods is still not positive
   always_comb begin
      for (int n = 0; n < srb_pkg::SAMPLE_SPAN; n++) begin
         due[n] = (left_w + signed'(srb_pkg::CMP_W'(n) * period_w)) <= 0;
      end
   end

   assign due_count = srb_pkg::BITCNT_W'($countones(due));

   // data bits still open in this frame; none once in stop check
   assign room = (state_in.phase == srb_pkg::PH_DATA)
                 ? srb_pkg::BITCNT_W'(srb_pkg::BYTE_W) - state_in.bit_count
                 : '0;
   assign take     = (due_count < room) ? due_count : room;
   assign stop_hit = due_count > room;

   // data lanes filled by this request's samples
   assign take_end = {1'b0, state_in.bit_count} + {1'b0, take};
   always_comb begin
      for (int i = 0; i < srb_pkg::BYTE_W; i++) begin
         fill_mask[i] = ((srb_pkg::BITCNT_W+1)'(i) >= {1'b0, state_in.bit_count})
                        && ((srb_pkg::BITCNT_W+1)'(i) < take_end);
      end
   end

   assign new_byte  = line_level ? (state_in.shift_byte | fill_mask) : state_in.shift_byte;
   assign new_count = state_in.bit_count + take;

   // phase sequencing
   always_comb begin
      state_out            = state_in;
      state_out.prev_level = line_level;
      emit                 = 1'b0;
      case (state_in.phase)
         srb_pkg::PH_DATA, srb_pkg::PH_STOP: begin
            state_out.counter    = srb_pkg::CNT_W'(left_w
                                   + signed'(srb_pkg::CMP_W'(take) * period_w));
            state_out.bit_count  = new_count;
            state_out.shift_byte = new_byte;
            if (stop_hit) begin
               state_out.phase = srb_pkg::PH_IDLE;
               if (line_level) begin
                  emit = 1'b1;
                  if (new_byte == cfg.caps_code) begin
                     state_out.caps_state = ~state_in.caps_state;
                  end else if (new_byte == cfg.layout_code) begin
                     state_out.layout_state = ~state_in.layout_state;
                  end
               end
            end else if (new_count >= srb_pkg::BITCNT_W'(srb_pkg::BYTE_W)) begin
               state_out.phase = srb_pkg::PH_STOP;
            end else begin
               state_out.phase = srb_pkg::PH_DATA;
            end
         end
         default: begin
            // idle: a falling edge opens a frame, first sample at 1.5 periods
            state_out.phase = srb_pkg::PH_IDLE;
            if (state_in.prev_level && !line_level) begin
               state_out.phase      = srb_pkg::PH_DATA;
               state_out.counter    = srb_pkg::CNT_W'({1'b0, cfg.bit_period}
                                      + {2'b00, cfg.bit_period[srb_pkg::BYTE_W-1:1]});
               state_out.bit_count  = '0;
               state_out.shift_byte = '0;
            end
         end
      endcase
   end

endmodule

### hw/rtl/srb_checker.sv
// Port-level checks for the serial line byte reassembler, attached by bind.
// Depends on the top level's clock, reset and channel ports only.
`timescale 1ns / 1ps

module srb_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready
);

   // a response waits until it is taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // reset empties the response register
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // every rising response comes from a request that the block took earlier
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("response without a request");

   // with no response pending the request side is open
   a_req_open: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request blocked with empty response register");

endmodule

bind serial_line_byte_reassembler srb_checker u_srb_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready)
);

### tb/sv/tb_serial_line_byte_reassembler.sv
// Self-checking testbench for serial_line_byte_reassembler: directed table, then random
// framed line traffic checked against an in-bench frame decoder. Uses srb_pkg and srb_if.
`timescale 1ns / 1ps

module tb_serial_line_byte_reassembler;

   // index with no register behind it, writes must be ignored
   localparam logic [srb_pkg::CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   typedef struct packed {
      logic [srb_pkg::BYTE_W-1:0] rx_byte;
      logic                       caps;
      logic                       layout;
   } byte_report_type;

   typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_type;

   typedef struct packed {
      row_kind_type                   kind;
      logic                           lvl;
      logic [srb_pkg::CYCLES_W-1:0]   cyc;
      logic [srb_pkg::CSR_IDX_W-1:0]  idx;
      logic [srb_pkg::BYTE_W-1:0]     wdata;
      logic                           typed;
      byte_report_type                want;
   } stim_row_type;

   localparam byte_report_type NO_REPORT = '0;

   logic clock;
   logic reset;

   srb_req_if req_bus ();
   srb_rsp_if rsp_bus ();
   srb_csr_if csr_bus ();

   serial_line_byte_reassembler u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   // register shadows
   logic [srb_pkg::BYTE_W-1:0] cfg_period = srb_pkg::BIT_PERIOD_RST;
   logic [srb_pkg::BYTE_W-1:0] cfg_caps   = srb_pkg::CAPS_CODE_RST;
   logic [srb_pkg::BYTE_W-1:0] cfg_layout = srb_pkg::LAYOUT_CODE_RST;

   // decoder state
   srb_pkg::phase_type         line_phase   = srb_pkg::PH_IDLE;
   int                         count_down   = 0;
   logic [3:0]                 bits_taken   = '0;
   logic [srb_pkg::BYTE_W-1:0] shift_acc    = '0;
   logic                       line_prev    = 1'b0;
   logic                       caps_state   = 1'b0;
   logic                       layout_state = 1'b0;

   byte_report_type pending_bytes [$];
   int              mismatch_count = 0;
   int              send_idle = 0;
   int              recv_idle = 0;

   // typed expectation for the directed row in flight
   logic            row_typed = 1'b0;
   byte_report_type row_want  = NO_REPORT;

   // random frame content
   logic [srb_pkg::BYTE_W-1:0] frame_byte = '0;
   logic                       frame_stop = 1'b1;

   // directed rows: reset case, bit period extremes, equal codes, zero cycles, bad stop
   stim_row_type directed_rows [28] = '{
      '{ROW_SAMPLE, 1'b0, 4'd15, srb_pkg::CSR_BIT_PERIOD,  8'h00, 1'b0, NO_REPORT},
      '{ROW_WRITE,  1'b0, 4'd0,  srb_pkg::CSR_BIT_PERIOD,  8'd2,  1'b0, NO_REPORT},
      '{ROW_SAMPLE, 1'b1, 4'd0,  srb_pkg::CSR_BIT_PERIOD,  8'h00, 1'b0, NO_REPORT},
      '{ROW_SAMPLE, 1'b0, 4'd15, srb_pkg::CSR_BIT_PERIOD,  8'h00, 1'b0, NO_REPORT},
      '{ROW_SAMPLE, 1'b1, 4'd15, srb_pkg::CSR_BIT_PERIOD,  8'h00, 1'b0, NO_REPORT},
      '{ROW_SAMPLE, 1'b1, 4'd15, srb_pkg::CSR_BIT_PERIOD,  8'h00, 1'b1, '{8'hFF, 1'b0, 1'b0}},
      '{ROW_SAMPLE, 1'b0, 4'd3,  srb_pkg::CSR_BIT_PERIOD,  8'h00, 1'b0, NO_REPORT},
      '{ROW_SAMPLE, 1'b0, 4'd3,  srb_pkg::CSR_BIT_PERIOD,  8'h00, 1'b0, NO_REPORT},
      '{ROW_SAMPLE, 1'b0, 4'd15, srb_pkg::CSR_BIT_PERIOD,  8'h00, 1'b0, NO_REPORT},
      '{ROW_SAMPLE, 1'b0, 4'd1,  srb_pkg::CSR_BIT_PERIOD,  8'h00, 1'b0, NO_REPORT},
      '{ROW_WRITE,  1'b0, 4'd0,  srb_pkg::CSR_CAPS_CODE,   8'hFF, 1'b0, NO_REPORT},
      '{ROW_WRITE,  1'b0, 4'd0,  srb_pkg::CSR_LAYOUT_CODE, 8'hFF, 1'b0, NO_REPORT},
      '{ROW_SAMPLE, 1'b1, 4'd0,  srb_pkg::CSR_BIT_PERIOD,  8'h00, 1'b0, NO_REPORT},
      '{ROW_SAMPLE, 1'b0, 4'd0,  srb_pkg::CSR_BIT_PERIOD,  8'h00, 1'b0, NO_REPORT},
      '{ROW_SAMPLE, 1'b1, 4'd15, srb_pkg::CSR_BIT_PERIOD,  8'h00, 1'b0, NO_REPORT},
      '{ROW_SAMPLE, 1'b1, 4'd15, srb_pkg::CSR_BIT_PERIOD,  8'h00, 1'b1, '{8'hFF, 1'b1, 1'b0}},
      '{ROW_WRITE,  1'b0, 4'd0,  srb_pkg::CSR_CAPS_CODE,   8'h00, 1'b0, NO_REPORT},
      '{ROW_WRITE,  1'b0, 4'd0,  srb_pkg::CSR_BIT_PERIOD,  8'd0,  1'b0, NO_REPORT},
      '{ROW_SAMPLE, 1'b0, 4'd0,  srb_pkg::CSR_BIT_PERIOD,  8'h00, 1'b0, NO_REPORT},
      '{ROW_SAMPLE, 1'b1, 4'd0,  srb_pkg::CSR_BIT_PERIOD,  8'h00, 1'b1, '{8'hFF, 1'b1, 1'b1}},
      '{ROW_SAMPLE, 1'b0, 4'd0,  srb_pkg::CSR_BIT_PERIOD,  8'h00, 1'b0, NO_REPORT},
      '{ROW_SAMPLE, 1'b0, 4'd7,  srb_pkg::CSR_BIT_PERIOD,  8'h00, 1'b0, NO_REPORT},
      '{ROW_WRITE,  1'b0, 4'd0,  srb_pkg::CSR_BIT_PERIOD,  8'd1,  1'b0, NO_REPORT},
      '{ROW_SAMPLE, 1'b1, 4'd0,  srb_pkg::CSR_BIT_PERIOD,  8'h00, 1'b0, NO_REPORT},
      '{ROW_SAMPLE, 1'b0, 4'd9,  srb_pkg::CSR_BIT_PERIOD,  8'h00, 1'b0, NO_REPORT},
      '{ROW_SAMPLE, 1'b1, 4'd0,  srb_pkg::CSR_BIT_PERIOD,  8'h00, 1'b0, NO_REPORT},
      '{ROW_SAMPLE, 1'b1, 4'd15, srb_pkg::CSR_BIT_PERIOD,  8'h00, 1'b1, '{8'hFF, 1'b1, 1'b0}},
      '{ROW_WRITE,  1'b0, 4'd0,  CSR_UNUSED,               8'h07, 1'b0, NO_REPORT}
   };

   // clock
   initial clock = 1'b0;
   always #2 clock = ~clock;

   // advance the frame decoder by one line sample, returns 1 when a byte comes out
   function automatic bit reassemble_sample(input logic lvl,
                                            input logic [srb_pkg::CYCLES_W-1:0] cyc,
                                            output byte_report_type rep);
      bit emitted;
      emitted = 1'b0;
      rep = NO_REPORT;
      if (line_phase == srb_pkg::PH_IDLE) begin
         // falling edge opens a frame, elapsed cycles of this request are not counted
         if (line_prev && !lvl) begin
            line_phase = srb_pkg::PH_DATA;
            count_down = int'(cfg_period) + int'(cfg_period) / 2;
            bits_taken = '0;
            shift_acc  = '0;
         end
      end else begin
         count_down = count_down - int'(cyc);
         // every sample due in this request takes the same level
         while (line_phase != srb_pkg::PH_IDLE && count_down <= 0) begin
            if (line_phase == srb_pkg::PH_DATA) begin
               if (lvl)
                  shift_acc[bits_taken[2:0]] = 1'b1;
               bits_taken = bits_taken + 4'd1;
               if (bits_taken >= 4'd8)
                  line_phase = srb_pkg::PH_STOP;
               count_down = count_down + int'(cfg_period);
            end else begin
               if (lvl) begin
                  if (shift_acc == cfg_caps)
                     caps_state = ~caps_state;
                  else if (shift_acc == cfg_layout)
                     layout_state = ~layout_state;
                  rep.rx_byte = shift_acc;
                  rep.caps    = caps_state;
                  rep.layout  = layout_state;
                  emitted = 1'b1;
               end
               line_phase = srb_pkg::PH_IDLE;
            end
         end
      end
      line_prev = lvl;
      return emitted;
   endfunction

   // each accepted request feeds the decoder
   always @(posedge clock) begin : take_request
      byte_report_type rep;
      bit              emitted;
      if (!reset && req_bus.valid && req_bus.ready) begin
         emitted = reassemble_sample(req_bus.line_level, req_bus.cycles_elapsed, rep);
         if (row_typed)
            pending_bytes.push_back(row_want);
         else if (emitted)
            pending_bytes.push_back(rep);
      end
   end

   // compare each accepted response with the oldest expected byte
   always @(posedge clock) begin : take_response
      byte_report_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_bytes.size() == 0) begin
            $error("unexpected response: received_byte %0h", rsp_bus.received_byte);
            mismatch_count++;
         end else begin
            want = pending_bytes.pop_front();
            if (rsp_bus.received_byte !== want.rx_byte) begin
               $error("received_byte: expected %0h, got %0h", want.rx_byte,
                      rsp_bus.received_byte);
               mismatch_count++;
            end
            if (rsp_bus.caps_flag !== want.caps) begin
               $error("caps_flag: expected %0b, got %0b", want.caps, rsp_bus.caps_flag);
               mismatch_count++;
            end
            if (rsp_bus.layout_flag !== want.layout) begin
               $error("layout_flag: expected %0b, got %0b", want.layout,
                      rsp_bus.layout_flag);
               mismatch_count++;
            end
         end
      end
   end

   // receiver stalls
   always @(negedge clock)
      rsp_bus.ready = ($urandom_range(99) >= recv_idle);

   // one line sample request, returns at the falling edge after acceptance
   task automatic send_sample(input logic lvl, input logic [srb_pkg::CYCLES_W-1:0] cyc);
      while ($urandom_range(99) < send_idle) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.valid          = 1'b1;
      req_bus.line_level     = lvl;
      req_bus.cycles_elapsed = cyc;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
   endtask

   // drain all expected bytes, then let the pipeline empty
   task automatic wait_for_quiet();
      req_bus.valid = 1'b0;
      while (pending_bytes.size() != 0)
         @(posedge clock);
      repeat (6) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_register(input logic [srb_pkg::CSR_IDX_W-1:0] idx,
                                 input logic [srb_pkg::BYTE_W-1:0] data);
      csr_bus.valid      = 1'b1;
      csr_bus.reg_index  = idx;
      csr_bus.write_data = data;
      do @(posedge clock); while (!csr_bus.ready);
      case (idx)
         srb_pkg::CSR_BIT_PERIOD:  cfg_period = data;
         srb_pkg::CSR_CAPS_CODE:   cfg_caps   = data;
         srb_pkg::CSR_LAYOUT_CODE: cfg_layout = data;
         default: ;
      endcase
      @(negedge clock);
      csr_bus.valid = 1'b0;
   endtask

   // mostly well formed frames aimed at the decoder state, some line noise
   task automatic run_random_block(input int n_items,
                                   input logic [srb_pkg::BYTE_W-1:0] period,
                                   input logic [srb_pkg::BYTE_W-1:0] caps,
                                   input logic [srb_pkg::BYTE_W-1:0] layout);
      logic                         lvl;
      logic [srb_pkg::CYCLES_W-1:0] cyc;
      int                           pick;
      wait_for_quiet();
      write_register(srb_pkg::CSR_BIT_PERIOD, period);
      write_register(srb_pkg::CSR_CAPS_CODE, caps);
      write_register(srb_pkg::CSR_LAYOUT_CODE, layout);
      for (int n = 0; n < n_items; n++) begin
         if (cfg_period > 8'd40 && $urandom_range(3) != 0)
            cyc = 4'd15;
         else
            cyc = srb_pkg::CYCLES_W'($urandom_range(15));
         if ($urandom_range(99) < 8) begin
            lvl = 1'($urandom_range(1));
         end else begin
            case (line_phase)
               srb_pkg::PH_IDLE: begin
                  if (line_prev && $urandom_range(99) < 35) begin
                     lvl  = 1'b0;
                     pick = $urandom_range(7);
                     case (pick)
                        0, 1:    frame_byte = cfg_caps;
                        2:       frame_byte = cfg_layout;
                        3:       frame_byte = 8'h00;
                        4:       frame_byte = 8'hFF;
                        default: frame_byte = srb_pkg::BYTE_W'($urandom_range(255));
                     endcase
                     frame_stop = ($urandom_range(99) < 85);
                  end else begin
                     lvl = 1'b1;
                  end
               end
               srb_pkg::PH_DATA: lvl = frame_byte[bits_taken[2:0]];
               default: lvl = frame_stop;
            endcase
         end
         send_sample(lvl, cyc);
      end
      // hold the line high until any open frame closes
      while (line_phase != srb_pkg::PH_IDLE)
         send_sample(1'b1, 4'd15);
   endtask

   // main sequence
   initial begin
      reset                  = 1'b1;
      req_bus.valid          = 1'b0;
      req_bus.line_level     = 1'b0;
      req_bus.cycles_elapsed = '0;
      rsp_bus.ready          = 1'b0;
      csr_bus.valid          = 1'b0;
      csr_bus.reg_index      = '0;
      csr_bus.write_data     = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_idle = 34;
      recv_idle = 87;
      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_WRITE) begin
            wait_for_quiet();
            write_register(directed_rows[i].idx, directed_rows[i].wdata);
         end else begin
            row_typed = directed_rows[i].typed;
            row_want  = directed_rows[i].want;
            send_sample(directed_rows[i].lvl, directed_rows[i].cyc);
         end
      end
      row_typed = 1'b0;

      for (int blk = 0; blk < 6; blk++) begin
         send_idle = (blk < 2) ? 34 : (blk < 4) ? 87 : 0;
         recv_idle = (blk < 2) ? 87 : (blk < 4) ? 34 : 0;
         case (blk)
            0:       run_random_block(290, 8'd2, srb_pkg::CAPS_CODE_RST,
                                      srb_pkg::LAYOUT_CODE_RST);
            1:       run_random_block(290, 8'd255, 8'h00, 8'hFF);
            2:       run_random_block(290, 8'd5, 8'hFF, 8'h00);
            3:       run_random_block(290, 8'd0, srb_pkg::BYTE_W'($urandom_range(255)),
                                      srb_pkg::BYTE_W'($urandom_range(255)));
            4:       run_random_block(290, 8'd1, 8'h37, 8'h37);
            default: run_random_block(290, srb_pkg::BYTE_W'($urandom_range(40, 2)),
                                      srb_pkg::BYTE_W'($urandom_range(255)),
                                      srb_pkg::BYTE_W'($urandom_range(255)));
         endcase
      end

      wait_for_quiet();
      if (mismatch_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   // watchdog
   initial begin
      #2000000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

### serial_line_byte_reassembler.f
hw/rtl/srb_pkg.sv
hw/rtl/srb_if.sv
hw/rtl/srb_frame_step.sv
hw/rtl/serial_line_byte_reassembler.sv
hw/rtl/srb_checker.sv
tb/sv/tb_serial_line_byte_reassembler.sv
